// ===== design/priority_task_scheduler_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pts_pkg.sv =====
// Package of the priority task scheduler: sizes, codes and helper functions.
// Used by the interface and top-level files of the block; depends on nothing.
`default_nettype none
package pts_pkg;
	localparam int NUM_PRIO    = 32;
	localparam int NUM_TASKS   = 16;
	localparam int PRIO_W      = $clog2(NUM_PRIO);
	localparam int TASK_W      = $clog2(NUM_TASKS);
	localparam int CNT_W       = TASK_W + 1;
	localparam int QADDR_W     = PRIO_W + TASK_W;
	localparam int QDEPTH      = NUM_PRIO * NUM_TASKS;
	localparam int CMD_W       = 3;
	localparam int TASK_ID_W   = 4;
	localparam int PRIO_IN_W   = 5;
	localparam int DELAY_W     = 32;
	localparam int SLICE_W     = 8;
	localparam int LOCK_W      = 8;
	localparam int LOCK_MAX    = 255;
	localparam int SLICE_RESET = 10;

	typedef enum logic [CMD_W-1:0] {
		CMD_READY    = 3'd0,
		CMD_UNREADY  = 3'd1,
		CMD_DELAY    = 3'd2,
		CMD_WAKE     = 3'd3,
		CMD_TICK     = 3'd4,
		CMD_LOCK     = 3'd5,
		CMD_UNLOCK   = 3'd6,
		CMD_SCHEDULE = 3'd7
	} cmd_t;

	// Returns the lowest set bit of a non-empty priority bitmap.
	function automatic logic [PRIO_W-1:0] first_set(input logic [NUM_PRIO-1:0] bits);
		logic [PRIO_W-1:0] idx;
		idx = '0;
		for (int i = NUM_PRIO - 1; i >= 0; i--) begin
			if (bits[i]) begin
				idx = PRIO_W'(i);
			end
		end
		return idx;
	endfunction
endpackage
`default_nettype wire

// ===== design/pts_if.sv =====
// Handshake channels of the scheduler: command items in, report items out.
// Depends on pts_pkg for the field widths.
`default_nettype none
interface pts_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [pts_pkg::CMD_W-1:0]     command;
	logic [pts_pkg::TASK_ID_W-1:0] task_id;
	logic [pts_pkg::PRIO_IN_W-1:0] task_prio;
	logic [pts_pkg::DELAY_W-1:0]   delay_ticks;
	modport source (output valid, command, task_id, task_prio, delay_ticks, input ready);
	modport sink (input valid, command, task_id, task_prio, delay_ticks, output ready);
endinterface

interface pts_res_if;
	logic                          valid;
	logic                          ready;
	logic [pts_pkg::TASK_ID_W-1:0] next_task;
	logic                          switch_now;
	logic                          none_ready;
	logic [pts_pkg::LOCK_W-1:0]    lock_depth;
	modport source (output valid, next_task, switch_now, none_ready, lock_depth, input ready);
	modport sink (input valid, next_task, switch_now, none_ready, lock_depth, output ready);
endinterface
`default_nettype wire

// ===== design/priority_task_scheduler.sv =====
// Top level of the priority task scheduler: command sequencer and queue state.
// Depends on pts_pkg, pts_if, pts_ram and the assertion macro header.
//
// One command item is taken at a time and one report item is produced for it.
// Lock, unlock, wake, delay and schedule go straight from idle to the report
// states. A ready or unready walks the task's queue in the ready-queue RAM,
// reading one entry at a time, to remove it, and ready then shifts the target
// queue down one entry at a time to insert at the head. A tick visits every
// task in turn, reads the delay counter of each delayed task, and every task
// it wakes costs a further ready walk; a rotation at slice expiry costs one
// removal walk. A new item is taken while the previous report still waits in
// the output register.
`default_nettype none
`include "priority_task_scheduler_macros.svh"
module priority_task_scheduler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [pts_pkg::SLICE_W-1:0] cfg_wdata,
	pts_cmd_if.sink                          cmd,
	pts_res_if.source                        res
);
	localparam int PW = pts_pkg::PRIO_W;
	localparam int TW = pts_pkg::TASK_W;
	localparam int CW = pts_pkg::CNT_W;
	localparam int AW = pts_pkg::QADDR_W;
	localparam int NP = pts_pkg::NUM_PRIO;
	localparam int NT = pts_pkg::NUM_TASKS;
	localparam int DW = pts_pkg::DELAY_W;
	localparam int SW = pts_pkg::SLICE_W;
	localparam int LW = pts_pkg::LOCK_W;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_TK_SCAN  = 11'b000_0000_0010,
		S_TK_CHK   = 11'b000_0000_0100,
		S_RM_RD    = 11'b000_0000_1000,
		S_RM_WT    = 11'b000_0001_0000,
		S_HD_START = 11'b000_0010_0000,
		S_HD_STEP  = 11'b000_0100_0000,
		S_HD_WT    = 11'b000_1000_0000,
		S_TL_PUT   = 11'b001_0000_0000,
		S_REP      = 11'b010_0000_0000,
		S_REP_WT   = 11'b100_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		CTX_READY   = 2'd0,
		CTX_UNREADY = 2'd1,
		CTX_TICK    = 2'd2,
		CTX_ROT     = 2'd3
	} ctx_t;

	state_t          state_q;
	ctx_t            ctx_q;
	logic [SW-1:0]   slice_reload_q;
	logic [NP-1:0]   bitmap_q;
	logic [CW-1:0]   count_q [NP];
	logic [PW-1:0]   prio_of_q [NT];
	logic [SW-1:0]   slice_q [NT];
	logic [NT-1:0]   mark_q;
	logic [TW-1:0]   current_q;
	logic [LW-1:0]   lock_q;
	logic [TW-1:0]   op_task_q;
	logic [PW-1:0]   op_prio_q;
	logic [PW-1:0]   new_prio_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   tick_q;
	logic            found_q;
	logic            none_q;

	logic            res_valid_q;
	logic [TW-1:0]   res_task_q;
	logic            res_sw_q;
	logic            res_none_q;
	logic [LW-1:0]   res_lock_q;

	logic            q_we, q_re;
	logic [AW-1:0]   q_waddr, q_raddr;
	logic [TW-1:0]   q_wdata, q_rdata;
	logic            d_we, d_re;
	logic [TW-1:0]   d_waddr, d_raddr;
	logic [DW-1:0]   d_wdata, d_rdata;

	logic            accept;
	logic            task_ok;
	logic [TW-1:0]   in_task;
	logic [PW-1:0]   in_prio;
	logic [CW-1:0]   cnt_cur;
	logic [TW-1:0]   tick_idx;
	logic            tick_done;
	logic [PW-1:0]   top_prio;
	logic [TW-1:0]   nxt;
	logic            sw;
	logic            out_free;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign task_ok   = int'(cmd.task_id) < NT;
	assign in_task   = TW'(cmd.task_id);
	assign in_prio   = (int'(cmd.task_prio) >= NP) ? PW'(NP - 1) : PW'(cmd.task_prio);
	assign cnt_cur   = count_q[op_prio_q];
	assign tick_idx  = tick_q[TW-1:0];
	assign tick_done = (tick_q == CW'(NT));
	assign top_prio  = pts_pkg::first_set(bitmap_q);
	assign nxt       = none_q ? '0 : q_rdata;
	assign sw        = !none_q && (lock_q == '0) && (nxt != current_q);
	assign out_free  = !res_valid_q || res.ready;

	assign res.valid      = res_valid_q;
	assign res.next_task  = pts_pkg::TASK_ID_W'(res_task_q);
	assign res.switch_now = res_sw_q;
	assign res.none_ready = res_none_q;
	assign res.lock_depth = res_lock_q;

	pts_ram #(.WIDTH(TW), .DEPTH(pts_pkg::QDEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	pts_ram #(.WIDTH(DW), .DEPTH(NT)) u_delay_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	always_comb begin
		q_we    = 1'b0;
		q_re    = 1'b0;
		q_waddr = '0;
		q_raddr = '0;
		q_wdata = '0;
		d_we    = 1'b0;
		d_re    = 1'b0;
		d_waddr = '0;
		d_raddr = '0;
		d_wdata = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && task_ok && cmd.command == pts_pkg::CMD_DELAY) begin
					d_we    = 1'b1;
					d_waddr = in_task;
					d_wdata = cmd.delay_ticks;
				end
			end
			S_TK_SCAN: begin
				if (!tick_done && mark_q[tick_idx]) begin
					d_re    = 1'b1;
					d_raddr = tick_idx;
				end
			end
			S_TK_CHK: begin
				d_we    = 1'b1;
				d_waddr = tick_idx;
				d_wdata = (d_rdata <= DW'(1)) ? '0 : d_rdata - DW'(1);
			end
			S_RM_RD: begin
				if (idx_q != cnt_cur) begin
					q_re    = 1'b1;
					q_raddr = {op_prio_q, idx_q[TW-1:0]};
				end
			end
			S_RM_WT: begin
				if (found_q) begin
					q_we    = 1'b1;
					q_waddr = {op_prio_q, idx_q[TW-1:0] - TW'(1)};
					q_wdata = q_rdata;
				end
			end
			S_HD_STEP: begin
				if (idx_q == '0) begin
					q_we    = 1'b1;
					q_waddr = {op_prio_q, TW'(0)};
					q_wdata = op_task_q;
				end else begin
					q_re    = 1'b1;
					q_raddr = {op_prio_q, idx_q[TW-1:0] - TW'(1)};
				end
			end
			S_HD_WT: begin
				q_we    = 1'b1;
				q_waddr = {op_prio_q, idx_q[TW-1:0]};
				q_wdata = q_rdata;
			end
			S_TL_PUT: begin
				if (cnt_cur < CW'(NT)) begin
					q_we    = 1'b1;
					q_waddr = {op_prio_q, cnt_cur[TW-1:0]};
					q_wdata = op_task_q;
				end
			end
			S_REP: begin
				if (bitmap_q != '0) begin
					q_re    = 1'b1;
					q_raddr = {top_prio, TW'(0)};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ctx_q          <= CTX_READY;
			slice_reload_q <= SW'(pts_pkg::SLICE_RESET);
			bitmap_q       <= '0;
			mark_q         <= '0;
			current_q      <= '0;
			lock_q         <= '0;
			res_valid_q    <= 1'b0;
			for (int i = 0; i < NP; i++) begin
				count_q[i] <= '0;
			end
			for (int i = 0; i < NT; i++) begin
				slice_q[i] <= SW'(pts_pkg::SLICE_RESET);
			end
		end else begin
			if (cfg_we) begin
				slice_reload_q <= cfg_wdata;
			end
			if (res.ready && state_q != S_REP_WT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_task_q  <= in_task;
						op_prio_q  <= prio_of_q[in_task];
						new_prio_q <= in_prio;
						idx_q      <= '0;
						found_q    <= 1'b0;
						tick_q     <= '0;
						case (cmd.command)
							pts_pkg::CMD_READY: begin
								if (task_ok) begin
									ctx_q   <= CTX_READY;
									state_q <= S_RM_RD;
								end else begin
									state_q <= S_REP;
								end
							end
							pts_pkg::CMD_UNREADY: begin
								if (task_ok) begin
									ctx_q   <= CTX_UNREADY;
									state_q <= S_RM_RD;
								end else begin
									state_q <= S_REP;
								end
							end
							pts_pkg::CMD_DELAY: begin
								if (task_ok) begin
									mark_q[in_task] <= 1'b1;
								end
								state_q <= S_REP;
							end
							pts_pkg::CMD_WAKE: begin
								if (task_ok) begin
									mark_q[in_task] <= 1'b0;
								end
								state_q <= S_REP;
							end
							pts_pkg::CMD_TICK: begin
								ctx_q   <= CTX_TICK;
								state_q <= S_TK_SCAN;
							end
							pts_pkg::CMD_LOCK: begin
								if (lock_q != LW'(pts_pkg::LOCK_MAX)) begin
									lock_q <= lock_q + LW'(1);
								end
								state_q <= S_REP;
							end
							pts_pkg::CMD_UNLOCK: begin
								if (lock_q != '0) begin
									lock_q <= lock_q - LW'(1);
								end
								state_q <= S_REP;
							end
							default: begin
								state_q <= S_REP;
							end
						endcase
					end
				end
				S_TK_SCAN: begin
					if (tick_done) begin
						if (slice_q[current_q] <= SW'(1)) begin
							slice_q[current_q] <= slice_reload_q;
							op_task_q          <= current_q;
							op_prio_q          <= prio_of_q[current_q];
							idx_q              <= '0;
							found_q            <= 1'b0;
							ctx_q              <= CTX_ROT;
							state_q            <= S_RM_RD;
						end else begin
							slice_q[current_q] <= slice_q[current_q] - SW'(1);
							state_q            <= S_REP;
						end
					end else if (mark_q[tick_idx]) begin
						state_q <= S_TK_CHK;
					end else begin
						tick_q <= tick_q + CW'(1);
					end
				end
				S_TK_CHK: begin
					if (d_rdata <= DW'(1)) begin
						mark_q[tick_idx] <= 1'b0;
						op_task_q        <= tick_idx;
						op_prio_q        <= prio_of_q[tick_idx];
						idx_q            <= '0;
						found_q          <= 1'b0;
						state_q          <= S_RM_RD;
					end else begin
						tick_q  <= tick_q + CW'(1);
						state_q <= S_TK_SCAN;
					end
				end
				S_RM_RD: begin
					if (idx_q != cnt_cur) begin
						state_q <= S_RM_WT;
					end else begin
						if (found_q) begin
							count_q[op_prio_q] <= cnt_cur - CW'(1);
							if (cnt_cur == CW'(1)) begin
								bitmap_q[op_prio_q] <= 1'b0;
							end
						end
						case (ctx_q)
							CTX_READY: begin
								prio_of_q[op_task_q] <= new_prio_q;
								op_prio_q            <= new_prio_q;
								state_q              <= S_HD_START;
							end
							CTX_TICK: begin
								state_q <= S_HD_START;
							end
							CTX_ROT: begin
								state_q <= found_q ? S_TL_PUT : S_REP;
							end
							default: begin
								state_q <= S_REP;
							end
						endcase
					end
				end
				S_RM_WT: begin
					if (!found_q && q_rdata == op_task_q) begin
						found_q <= 1'b1;
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= S_RM_RD;
				end
				S_HD_START: begin
					if (cnt_cur >= CW'(NT)) begin
						if (ctx_q == CTX_TICK) begin
							tick_q  <= tick_q + CW'(1);
							state_q <= S_TK_SCAN;
						end else begin
							state_q <= S_REP;
						end
					end else begin
						idx_q   <= cnt_cur;
						state_q <= S_HD_STEP;
					end
				end
				S_HD_STEP: begin
					if (idx_q == '0) begin
						count_q[op_prio_q]  <= cnt_cur + CW'(1);
						bitmap_q[op_prio_q] <= 1'b1;
						if (ctx_q == CTX_TICK) begin
							tick_q  <= tick_q + CW'(1);
							state_q <= S_TK_SCAN;
						end else begin
							state_q <= S_REP;
						end
					end else begin
						state_q <= S_HD_WT;
					end
				end
				S_HD_WT: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= S_HD_STEP;
				end
				S_TL_PUT: begin
					if (cnt_cur < CW'(NT)) begin
						count_q[op_prio_q]  <= cnt_cur + CW'(1);
						bitmap_q[op_prio_q] <= 1'b1;
					end
					state_q <= S_REP;
				end
				S_REP: begin
					none_q  <= (bitmap_q == '0);
					state_q <= S_REP_WT;
				end
				S_REP_WT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_task_q  <= nxt;
						res_sw_q    <= sw;
						res_none_q  <= none_q;
						res_lock_q  <= lock_q;
						if (sw) begin
							current_q <= nxt;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PTS_ASSERT_SAME(a_switch_unlocked, res.valid && res.switch_now, res.lock_depth == '0 && !res.none_ready, "switch reported while locked or with nothing ready")
	`PTS_ASSERT_SAME(a_none_zero_task, res.valid && res.none_ready, res.next_task == '0, "empty report carries a task")
	`PTS_ASSERT_SAME(a_report_then_idle, $rose(res.valid), state_q == S_IDLE, "report loaded without returning to idle")
	`PTS_ASSERT_NEXT(a_tick_scan_bound, state_q == S_TK_SCAN, tick_q <= CW'(NT), "tick scan ran past the last task")
endmodule
`default_nettype wire

// ===== design/pts_ram.sv =====
// Simple dual-port synchronous RAM with one write and one registered read port.
// Generic; no package dependency.
`default_nettype none
module pts_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire
